// ----- rtl/core/fuls_pkg.sv -----
// fuls_pkg: shared types and constants for first_unique_letter_stream.
// No dependencies.
package fuls_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int CNT_W         = 2;
  localparam int PTR_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int QCNT_W        = $clog2(ALPHABET_SIZE + 1);

  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QFILL_W       = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(2);

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                start_new;
    logic                in_range;
  } cmd_t;

endpackage

// ----- rtl/core/fuls_if.sv -----
// fuls_if: valid/ready channel interfaces for letter input and answer output.
// Depends on fuls_pkg.
interface fuls_in_if;
  logic                          valid;
  logic                          ready;
  logic [fuls_pkg::LETTER_W-1:0] letter;
  logic                          start_new;

  modport source (output valid, output letter, output start_new, input ready);
  modport sink   (input valid, input letter, input start_new, output ready);
endinterface

interface fuls_out_if;
  logic                          valid;
  logic                          ready;
  logic                          has_answer;
  logic [fuls_pkg::LETTER_W-1:0] answer_letter;

  modport source (output valid, output has_answer, output answer_letter, input ready);
  modport sink   (input valid, input has_answer, input answer_letter, output ready);
endinterface

// ----- rtl/core/fuls_front.sv -----
// fuls_front: accepts input transfers, flags out-of-range codes and queues commands.
// Depends on fuls_pkg and fuls_if.
module fuls_front (
  input  logic             clk,
  input  logic             rst_n,
  fuls_in_if.sink          in_ch,
  output logic             cmd_valid,
  output fuls_pkg::cmd_t   cmd,
  input  logic             cmd_pop
);

  fuls_pkg::cmd_t                      q_r [fuls_pkg::QDEPTH];
  logic [fuls_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [fuls_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [fuls_pkg::QFILL_W-1:0]        fill_r, fill_nxt;
  logic                                push;
  fuls_pkg::cmd_t                      new_cmd;

  assign in_ch.ready = (fill_r < fuls_pkg::QFILL_W'(fuls_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill_r != '0);
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.letter    = in_ch.letter;
    new_cmd.start_new = in_ch.start_new;
    new_cmd.in_range  = (int'(in_ch.letter) < fuls_pkg::ALPHABET_SIZE);
  end

  function automatic logic [fuls_pkg::QPTR_W-1:0] qinc(input logic [fuls_pkg::QPTR_W-1:0] p);
    return (p == fuls_pkg::QPTR_W'(fuls_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? qinc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? qinc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r + fuls_pkg::QFILL_W'(push) - fuls_pkg::QFILL_W'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= fuls_pkg::QFILL_W'(fuls_pkg::QDEPTH))
    else $error("command queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");
`endif

endmodule

// ----- rtl/core/fuls_back.sv -----
// fuls_back: per-letter counts, first-seen order ring, head drop loop, answer register.
// Depends on fuls_pkg and fuls_if.
module fuls_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  fuls_pkg::cmd_t   cmd,
  output logic             cmd_pop,
  fuls_out_if.source       out_ch
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DROP = 1'b1;

  logic                              state_r, state_nxt;
  logic [fuls_pkg::CNT_W-1:0]        counts_r [fuls_pkg::ALPHABET_SIZE];
  logic [fuls_pkg::LETTER_W-1:0]     ring_r   [fuls_pkg::ALPHABET_SIZE];
  logic [fuls_pkg::PTR_W-1:0]        head_r, head_nxt;
  logic [fuls_pkg::PTR_W-1:0]        tail_r, tail_nxt;
  logic [fuls_pkg::QCNT_W-1:0]       qcnt_r, qcnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_has_r, out_has_nxt;
  logic [fuls_pkg::LETTER_W-1:0]     out_letter_r, out_letter_nxt;

  logic [fuls_pkg::LETTER_W-1:0]     head_letter;
  logic [fuls_pkg::PTR_W-1:0]        rd_addr;
  logic [fuls_pkg::CNT_W-1:0]        cnt_rd, cnt_old, cnt_new;
  logic                              do_push, do_drop, out_free;
  logic [fuls_pkg::PTR_W-1:0]        tail_base;
  logic [fuls_pkg::QCNT_W-1:0]       qcnt_base;

  function automatic logic [fuls_pkg::PTR_W-1:0] rinc(input logic [fuls_pkg::PTR_W-1:0] p);
    return (p == fuls_pkg::PTR_W'(fuls_pkg::ALPHABET_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_ch.valid         = out_valid_r;
  assign out_ch.has_answer    = out_has_r;
  assign out_ch.answer_letter = out_letter_r;
  assign out_free             = !out_valid_r || out_ch.ready;

  assign cmd_pop     = (state_r == S_IDLE) && cmd_valid;
  assign head_letter = ring_r[head_r];
  // single count read port: incoming letter in idle, head letter while dropping
  assign rd_addr     = (state_r == S_IDLE) ? fuls_pkg::PTR_W'(cmd.letter)
                                           : fuls_pkg::PTR_W'(head_letter);
  assign cnt_rd      = counts_r[rd_addr];
  assign cnt_old     = cmd.start_new ? '0 : cnt_rd;
  assign cnt_new     = (cnt_old < fuls_pkg::CNT_SAT) ? cnt_old + 1'b1 : cnt_old;
  assign tail_base   = cmd.start_new ? '0 : tail_r;
  assign qcnt_base   = cmd.start_new ? '0 : qcnt_r;
  assign do_push     = cmd_pop && cmd.in_range && (cnt_old == '0) &&
                       (qcnt_base < fuls_pkg::QCNT_W'(fuls_pkg::ALPHABET_SIZE));
  assign do_drop     = (state_r == S_DROP) && (qcnt_r != '0) &&
                       (int'(head_letter) < fuls_pkg::ALPHABET_SIZE) &&
                       (cnt_rd > fuls_pkg::CNT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    qcnt_nxt       = qcnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_has_nxt    = out_has_r;
    out_letter_nxt = out_letter_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_pop) begin
          if (cmd.start_new) begin
            head_nxt = '0;
          end
          tail_nxt  = do_push ? rinc(tail_base) : tail_base;
          qcnt_nxt  = qcnt_base + fuls_pkg::QCNT_W'(do_push);
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (do_drop) begin
          head_nxt = rinc(head_r);
          qcnt_nxt = qcnt_r - 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_has_nxt    = (qcnt_r != '0);
          out_letter_nxt = (qcnt_r != '0) ? head_letter : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
      counts_r    <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd_pop && cmd.start_new) begin
        counts_r <= '{default: '0};
      end
      if (cmd_pop && cmd.in_range) begin
        counts_r[rd_addr] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_has_r    <= out_has_nxt;
    out_letter_r <= out_letter_nxt;
    if (do_push) begin
      ring_r[tail_base] <= cmd.letter;
    end
  end

`ifndef SYNTH
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= fuls_pkg::QCNT_W'(fuls_pkg::ALPHABET_SIZE))
    else $error("order ring count out of range");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (qcnt_r == '0) |-> (head_r == tail_r))
    else $error("empty ring with unequal pointers");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> (out_letter_r == '0))
    else $error("answer letter nonzero without answer");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (state_r == S_DROP))
    else $error("command taken without entering drop phase");
`endif

endmodule

// ----- rtl/core/first_unique_letter_stream.sv -----
// first_unique_letter_stream: top level, front queue plus back engine.
// Depends on fuls_pkg, fuls_if, fuls_front and fuls_back.
//
// Reports, for every letter transfer, the earliest letter of the current string
// that has occurred exactly once (has_answer = 0 and answer_letter = 0 if none).
// start_new clears the string before its own letter; codes at or above the
// alphabet size change nothing. A two-entry command queue decouples the input
// from the engine. The engine first updates the letter count and the first-seen
// ring (idle state), then drops head letters whose count exceeds one (drop
// state), at most one drop per distinct letter per string, and then registers
// the answer; it takes the next command only after registering the answer.
// The answer register lets the next letter be processed while a result waits.
// No clearing pass after reset.
module first_unique_letter_stream (
  input  logic       clk,
  input  logic       rst_n,
  fuls_in_if.sink    in_ch,
  fuls_out_if.source out_ch
);

  logic           cmd_valid;
  logic           cmd_pop;
  fuls_pkg::cmd_t cmd;

  fuls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fuls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule
